// ===== rtl/weighted_histogram_mode_engine_unit_macros.svh =====
// Assertion macros for the weighted histogram mode engine.
`ifndef WEIGHTED_HISTOGRAM_MODE_ENGINE_UNIT_MACROS_SVH
`define WEIGHTED_HISTOGRAM_MODE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WHM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("whm assertion failed");

// Next-cycle implication, checked through reset as well.
`define WHM_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("whm assertion failed");

`endif

// ===== rtl/whm_pkg.sv =====
// Package: types, widths and codes of the weighted histogram mode engine.
`timescale 1ns / 1ps
package whm_pkg;

   localparam int MAX_BINS_DEF = 256;
   localparam int CMD_W        = 2;
   localparam int VALUE_W      = 16;
   localparam int WEIGHT_W     = 16;
   localparam int RANGE_W      = 9;
   localparam int CFG_W        = 9;
   localparam int BIN_W        = 8;
   localparam int COUNT_W      = 40;
   localparam int TOTAL_W      = 48;
   localparam int WSUM_W       = 56;
   localparam int PROD_W       = BIN_W + WEIGHT_W;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CFG_W-1:0]   BINS_RESET = 9'd256;
   localparam logic [RANGE_W-1:0] MODE_NONE  = 9'h1FF;

   localparam logic [CMD_W-1:0] CMD_INCREMENT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VALUE_W-1:0] bin_value;
      logic [WEIGHT_W-1:0] weight;
      logic [RANGE_W-1:0] range_low;
      logic [RANGE_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic signed [RANGE_W-1:0] mode_bin;
      logic [COUNT_W-1:0]        mode_count;
      logic [TOTAL_W-1:0]        range_total;
      logic [TOTAL_W-1:0]        overall_total;
      logic [WSUM_W-1:0]         weighted_sum;
   } rsp_type;

   // Classified work item handed from the front end to the back end.
   typedef struct packed {
      logic [CMD_W-1:0]    op;
      logic [BIN_W-1:0]    bin;
      logic [WEIGHT_W-1:0] weight;
      logic [RANGE_W-1:0]  lo;
      logic [RANGE_W-1:0]  hi;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INC  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

endpackage

// ===== rtl/whm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module whm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/whm_fifo.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module whm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  whm_pkg::job_type wr_job,
   output logic             full,
   input  logic             pop,
   output whm_pkg::job_type rd_job,
   output logic             valid
);

   localparam int PW = (whm_pkg::QUEUE_DEPTH > 1) ? $clog2(whm_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(whm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(whm_pkg::QUEUE_DEPTH - 1);

   whm_pkg::job_type entry_ff [whm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(whm_pkg::QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rd_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== rtl/whm_front.sv =====
// Front end: bins-in-use register, command decode, bin and range clamping.
`timescale 1ns / 1ps
module whm_front #(
   parameter int MAX_BINS = whm_pkg::MAX_BINS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [whm_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                        push,
   input  whm_pkg::req_type            req_data,
   input  logic                        q_full,
   output logic                        q_push,
   output whm_pkg::job_type            q_job
);

   localparam logic [whm_pkg::CFG_W-1:0] NMAX = whm_pkg::CFG_W'(MAX_BINS);

   logic [whm_pkg::CFG_W-1:0] bins_ff, bins_in;
   logic [whm_pkg::CFG_W-1:0] n_eff;
   logic [whm_pkg::CFG_W-1:0] n_last;
   logic                      known_cmd;

   always_comb begin
      bins_in = csr_wr_en ? csr_wr_data : bins_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff <= whm_pkg::BINS_RESET;
      end else begin
         bins_ff <= bins_in;
      end
   end

   always_comb begin
      if (bins_ff == '0) begin
         n_eff = whm_pkg::CFG_W'(1);
      end else if (bins_ff > NMAX) begin
         n_eff = NMAX;
      end else begin
         n_eff = bins_ff;
      end
      n_last = n_eff - 1'b1;
   end

   always_comb begin
      unique case (req_data.command) inside
         whm_pkg::CMD_INCREMENT, whm_pkg::CMD_CLEAR, whm_pkg::CMD_QUERY: known_cmd = 1'b1;
         default: known_cmd = 1'b0;
      endcase
   end

   always_comb begin
      q_job.op     = req_data.command;
      q_job.weight = req_data.weight;
      q_job.lo     = req_data.range_low;
      // values past the bins in use land in the last bin
      if (req_data.bin_value >= whm_pkg::VALUE_W'(n_eff)) begin
         q_job.bin = whm_pkg::BIN_W'(n_last);
      end else begin
         q_job.bin = whm_pkg::BIN_W'(req_data.bin_value);
      end
      q_job.hi = (req_data.range_high > n_eff) ? n_eff : req_data.range_high;
   end

   // unused command codes are taken and dropped
   assign q_push = push && !q_full && known_cmd;

endmodule

// ===== rtl/whm_back.sv =====
// Back end: bin memory read-modify-write, clear, range scan and result register.
`timescale 1ns / 1ps
module whm_back #(
   parameter int MAX_BINS = whm_pkg::MAX_BINS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  whm_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output whm_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_BINS);
   localparam int CNT_W = whm_pkg::COUNT_W;
   localparam int TOT_W = whm_pkg::TOTAL_W;
   localparam int WS_W  = whm_pkg::WSUM_W;
   localparam int RW    = whm_pkg::RANGE_W;

   whm_pkg::state_type state_ff, state_in;

   logic [MAX_BINS-1:0]           valid_ff, valid_in;
   logic [TOT_W-1:0]              run_total_ff, run_total_in;
   logic [WS_W-1:0]               run_wsum_ff, run_wsum_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pend_ff, pend_in;

   logic [whm_pkg::BIN_W-1:0]     inc_bin_ff, inc_bin_in;
   logic [whm_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [whm_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [RW-1:0]                 idx_ff, idx_in;
   logic [RW-1:0]                 hi_ff, hi_in;
   logic [RW-1:0]                 pidx_ff, pidx_in;
   logic [CNT_W-1:0]              best_ff, best_in;
   logic [RW-1:0]                 mode_ff, mode_in;
   logic [TOT_W-1:0]              rtot_ff, rtot_in;
   whm_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          ram_wr_en, ram_rd_en;
   logic [IW-1:0]                 ram_wr_addr, ram_rd_addr;
   logic [CNT_W-1:0]              ram_wr_data, ram_rd_data;

   logic [IW-1:0]                 look_addr;
   logic [CNT_W-1:0]              cnt_old;
   logic [CNT_W:0]                bin_sum;
   logic [TOT_W:0]                tot_sum;
   logic [WS_W:0]                 wsum_sum;
   logic [TOT_W:0]                rtot_sum;
   logic                          rsp_load;

   whm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a bin never written since reset or clear reads as zero
   assign look_addr = (state_ff == whm_pkg::ST_INC) ? inc_bin_ff[IW-1:0] : pidx_ff[IW-1:0];
   assign cnt_old   = valid_ff[look_addr] ? ram_rd_data : '0;

   assign bin_sum  = (CNT_W+1)'(cnt_old) + (CNT_W+1)'(weight_ff);
   assign tot_sum  = (TOT_W+1)'(run_total_ff) + (TOT_W+1)'(weight_ff);
   assign wsum_sum = (WS_W+1)'(run_wsum_ff) + (WS_W+1)'(prod_ff);
   assign rtot_sum = (TOT_W+1)'(rtot_ff) + (TOT_W+1)'(cnt_old);

   assign rsp_load = (state_ff == whm_pkg::ST_RESP) && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      run_total_in = run_total_ff;
      run_wsum_in  = run_wsum_ff;
      pend_in      = 1'b0;
      inc_bin_in   = inc_bin_ff;
      weight_in    = weight_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      pidx_in      = pidx_ff;
      best_in      = best_ff;
      mode_in      = mode_ff;
      rtot_in      = rtot_ff;
      job_pop      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = inc_bin_ff[IW-1:0];
      ram_wr_data  = bin_sum[CNT_W] ? '1 : bin_sum[CNT_W-1:0];
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[IW-1:0];

      unique case (state_ff)
         whm_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               case (job.op)
                  whm_pkg::CMD_INCREMENT: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = job.bin[IW-1:0];
                     inc_bin_in  = job.bin;
                     weight_in   = job.weight;
                     prod_in     = whm_pkg::PROD_W'(job.bin) * whm_pkg::PROD_W'(job.weight);
                     state_in    = whm_pkg::ST_INC;
                  end
                  whm_pkg::CMD_CLEAR: begin
                     valid_in     = '0;
                     run_total_in = '0;
                     run_wsum_in  = '0;
                  end
                  whm_pkg::CMD_QUERY: begin
                     // an empty range falls straight through the scan
                     idx_in   = job.lo;
                     hi_in    = job.hi;
                     best_in  = '0;
                     mode_in  = whm_pkg::MODE_NONE;
                     rtot_in  = '0;
                     state_in = whm_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         whm_pkg::ST_INC: begin
            ram_wr_en              = 1'b1;
            valid_in[look_addr]    = 1'b1;
            run_total_in = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
            run_wsum_in  = wsum_sum[WS_W] ? '1 : wsum_sum[WS_W-1:0];
            state_in     = whm_pkg::ST_IDLE;
         end
         whm_pkg::ST_SCAN: begin
            // read one bin per cycle; data is folded in the cycle after
            if (idx_ff < hi_ff) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               pidx_in   = idx_ff;
               idx_in    = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = whm_pkg::ST_RESP;
            end
            if (pend_ff) begin
               if (cnt_old > best_ff) begin
                  best_in = cnt_old;
                  mode_in = pidx_ff;
               end
               rtot_in = rtot_sum[TOT_W] ? '1 : rtot_sum[TOT_W-1:0];
            end
         end
         whm_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = whm_pkg::ST_IDLE;
            end
         end
         default: state_in = whm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.mode_bin      = $signed(mode_ff);
         rsp_in.mode_count    = best_ff;
         rsp_in.range_total   = rtot_ff;
         rsp_in.overall_total = run_total_ff;
         rsp_in.weighted_sum  = run_wsum_ff;
         rsp_valid_in         = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= whm_pkg::ST_IDLE;
         valid_ff     <= '0;
         run_total_ff <= '0;
         run_wsum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         run_total_ff <= run_total_in;
         run_wsum_ff  <= run_wsum_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_bin_ff <= inc_bin_in;
      weight_ff  <= weight_in;
      prod_ff    <= prod_in;
      idx_ff     <= idx_in;
      hi_ff      <= hi_in;
      pidx_ff    <= pidx_in;
      best_ff    <= best_in;
      mode_ff    <= mode_in;
      rtot_ff    <= rtot_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/weighted_histogram_mode_engine_unit.sv =====
// Weighted histogram mode engine: top level.
// Use: requests go in through push/full/req_data, one per transfer; a transfer
// happens when push is high and full is low. Command 0 adds the weight to a bin,
// command 1 clears all bins and sums, command 2 queries a bin range; command 3 is
// taken and dropped. Only queries give a result, read through empty/pop/rsp_data:
// the oldest result is on rsp_data while empty is low and leaves on pop.
// csr_wr_en/csr_wr_data write bins_in_use; the user must do so only while the
// block is idle, as the block itself does not enforce it. Flow: the front end
// classifies and enqueues a request in the transfer cycle into a two-entry
// queue. The back end takes one job at a time from it: an increment reads the
// bin memory, then writes it; a clear resets the bins and sums; a query scans
// the range through the one read port of the bin memory, one bin per cycle.
// Reset: bins_in_use returns to 256, all bins and sums read as zero at once
// (per-bin valid flags), no sweep. If the result register is held full, a
// further query waits in the back end; increments and clears before it proceed,
// and requests keep entering until the queue fills.
`timescale 1ns / 1ps
`include "weighted_histogram_mode_engine_unit_macros.svh"
module weighted_histogram_mode_engine_unit #(
   parameter int MAX_BINS = whm_pkg::MAX_BINS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  whm_pkg::req_type          req_data,
   output logic                      empty,
   input  logic                      pop,
   output whm_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [whm_pkg::CFG_W-1:0] csr_wr_data
);

   logic             q_push;
   logic             q_full;
   whm_pkg::job_type q_wr_job;
   whm_pkg::job_type q_rd_job;
   logic             q_valid;
   logic             q_pop;

   whm_front #(
      .MAX_BINS (MAX_BINS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_wr_job)
   );

   whm_fifo u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (q_wr_job),
      .full   (q_full),
      .pop    (q_pop),
      .rd_job (q_rd_job),
      .valid  (q_valid)
   );

   whm_back #(
      .MAX_BINS (MAX_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_rd_job),
      .job_pop   (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

   assign full = q_full;

   `WHM_ASSERT_IMPL(a_pop_needs_job, clock, reset, q_pop, q_valid)
   `WHM_ASSERT_IMPL(a_no_push_when_full, clock, reset, q_full, !q_push)
   `WHM_ASSERT_IMPL(a_push_only_on_transfer, clock, reset, q_push, push && !full)
   `WHM_ASSERT_NEXT(a_empty_after_reset, clock, reset, empty && !full)

endmodule
